@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file sls_checker.sv
// each macro samples on clk_i and is disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain concurrent assertion on the rising clock edge
`define SLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication, consequent checked in the cycle after the antecedent
`define SLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sls_pkg.sv @@
// shared types, constants and helper functions of the servo slew limiter
// no dependencies
package sls_pkg;

  localparam int unsigned NUM_SERVOS = 8;
  localparam int unsigned IDX_W      = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
  localparam int unsigned ANGLE_W    = 8;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CH_W       = 3;
  localparam int unsigned TICK_W     = 10;

  typedef logic [ANGLE_W-1:0] angle_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [TICK_W-1:0]  tick_t;

  localparam angle_t MAX_ANGLE         = 8'd180;
  localparam angle_t RESET_ANGLE       = 8'd90;
  localparam tick_t  TICK_MAX          = {TICK_W{1'b1}};
  localparam tick_t  STEP_INTERVAL_RST = 10'd20;
  localparam idx_t   LAST_IDX          = idx_t'(NUM_SERVOS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 2'd0,
    OP_SET_TARGET = 2'd1,
    OP_PRESET     = 2'd2,
    OP_UNUSED     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SET,
    ST_PRESET,
    ST_STEP
  } state_e;

  typedef struct packed {
    angle_t cur;
    angle_t tgt;
    angle_t settled;
  } entry_t;

  localparam entry_t RESET_ENTRY = '{cur: RESET_ANGLE, tgt: RESET_ANGLE, settled: RESET_ANGLE};

  typedef struct packed {
    logic   rd_en;
    idx_t   rd_addr;
    logic   wr_en;
    idx_t   wr_addr;
    entry_t wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [CH_W-1:0] index;
    angle_t          angle;
    logic            moved;
    logic            arrived;
    logic            last;
  } result_t;

  function automatic angle_t clamp_angle(input angle_t a);
    return (a > MAX_ANGLE) ? MAX_ANGLE : a;
  endfunction

  // true when the two angles are more than one degree apart
  function automatic logic far_apart(input angle_t a, input angle_t b);
    logic [ANGLE_W:0] ea;
    logic [ANGLE_W:0] eb;
    ea = {1'b0, a};
    eb = {1'b0, b};
    return (ea > eb + 1'b1) || (eb > ea + 1'b1);
  endfunction

endpackage

@@ rtl/sls_store.sv @@
// per-channel angle store: current, target and settled angle in one word
// depends on sls_pkg; one read and one write port, registered read data
module sls_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sls_pkg::mem_req_t req_i,
  output sls_pkg::entry_t   rd_data_o
);

  sls_pkg::entry_t                    mem_q [sls_pkg::NUM_SERVOS];
  sls_pkg::entry_t                    rd_q;
  logic [sls_pkg::NUM_SERVOS-1:0]     vld_q;
  logic                               rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_addr];
    end
  end

  // entries never written read as the reset angles
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : sls_pkg::RESET_ENTRY;

endmodule

@@ rtl/sls_seq.sv @@
// sequencer: decodes transactions, runs the per-channel step walk,
// keeps pending flag, tick count and arrival flags; depends on sls_pkg
module sls_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  sls_pkg::tick_t                 cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sls_pkg::OP_W-1:0]       operation_i,
  input  logic [sls_pkg::CH_W-1:0]       channel_i,
  input  sls_pkg::angle_t                angle_i,
  output sls_pkg::mem_req_t              mem_req_o,
  input  sls_pkg::entry_t                rd_data_i,
  input  logic                           out_free_i,
  output logic                           out_load_o,
  output sls_pkg::result_t               out_res_o
);

  sls_pkg::state_e                state_q, state_d;
  sls_pkg::tick_t                 step_interval_q;
  sls_pkg::tick_t                 tick_cnt_q, tick_cnt_d;
  logic                           pending_q, pending_d;
  logic [sls_pkg::NUM_SERVOS-1:0] mis_q, mis_d;
  logic [sls_pkg::NUM_SERVOS-1:0] far_q, far_d;
  logic                           arrived_q, arrived_d;
  sls_pkg::idx_t                  idx_q, idx_d;
  sls_pkg::angle_t                angle_q, angle_d;

  sls_pkg::tick_t                 tick_next;
  logic                           step_now;
  logic                           ch_ok;
  sls_pkg::op_e                   op;
  sls_pkg::angle_t                step_cur;
  logic                           step_moved;
  sls_pkg::angle_t                set_tgt;

  assign op        = sls_pkg::op_e'(operation_i);
  assign ch_ok     = 32'(channel_i) < sls_pkg::NUM_SERVOS;
  assign tick_next = (tick_cnt_q == sls_pkg::TICK_MAX) ? tick_cnt_q
                                                       : sls_pkg::TICK_W'(tick_cnt_q + 1'b1);
  assign step_now  = pending_q && (tick_next >= step_interval_q);

  // one degree toward target
  always_comb begin
    step_cur   = rd_data_i.cur;
    step_moved = 1'b0;
    if (rd_data_i.cur < rd_data_i.tgt) begin
      step_cur   = sls_pkg::ANGLE_W'(rd_data_i.cur + 1'b1);
      step_moved = 1'b1;
    end else if (rd_data_i.cur > rd_data_i.tgt) begin
      step_cur   = sls_pkg::ANGLE_W'(rd_data_i.cur - 1'b1);
      step_moved = 1'b1;
    end
  end

  assign set_tgt = (rd_data_i.settled != angle_q) ? angle_q : rd_data_i.settled;

  always_comb begin
    state_d    = state_q;
    tick_cnt_d = tick_cnt_q;
    pending_d  = pending_q;
    mis_d      = mis_q;
    far_d      = far_q;
    arrived_d  = arrived_q;
    idx_d      = idx_q;
    angle_d    = angle_q;
    mem_req_o  = '0;
    out_load_o = 1'b0;
    out_res_o  = '0;
    in_stall_o = (state_q != sls_pkg::ST_IDLE);

    unique case (state_q)
      sls_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (op)
            sls_pkg::OP_TICK: begin
              if (step_now) begin
                tick_cnt_d        = '0;
                idx_d             = '0;
                arrived_d         = ~|far_q;
                mem_req_o.rd_en   = 1'b1;
                mem_req_o.rd_addr = '0;
                state_d           = sls_pkg::ST_STEP;
              end else begin
                tick_cnt_d = tick_next;
              end
            end
            sls_pkg::OP_SET_TARGET: begin
              if (ch_ok) begin
                idx_d             = sls_pkg::IDX_W'(channel_i);
                angle_d           = sls_pkg::clamp_angle(angle_i);
                mem_req_o.rd_en   = 1'b1;
                mem_req_o.rd_addr = sls_pkg::IDX_W'(channel_i);
                state_d           = sls_pkg::ST_SET;
              end
            end
            sls_pkg::OP_PRESET: begin
              if (ch_ok) begin
                idx_d   = sls_pkg::IDX_W'(channel_i);
                angle_d = sls_pkg::clamp_angle(angle_i);
                state_d = sls_pkg::ST_PRESET;
              end
            end
            default: ;
          endcase
        end
      end

      sls_pkg::ST_SET: begin
        if (rd_data_i.settled != angle_q) begin
          pending_d = 1'b1;
        end
        mem_req_o.wr_en           = 1'b1;
        mem_req_o.wr_addr         = idx_q;
        mem_req_o.wr_data.cur     = rd_data_i.cur;
        mem_req_o.wr_data.tgt     = set_tgt;
        mem_req_o.wr_data.settled = rd_data_i.settled;
        mis_d[idx_q]              = rd_data_i.cur != set_tgt;
        far_d[idx_q]              = sls_pkg::far_apart(rd_data_i.cur, set_tgt);
        state_d                   = sls_pkg::ST_IDLE;
      end

      sls_pkg::ST_PRESET: begin
        if (out_free_i) begin
          mem_req_o.wr_en           = 1'b1;
          mem_req_o.wr_addr         = idx_q;
          mem_req_o.wr_data.cur     = angle_q;
          mem_req_o.wr_data.tgt     = angle_q;
          mem_req_o.wr_data.settled = angle_q;
          mis_d[idx_q]              = 1'b0;
          far_d[idx_q]              = 1'b0;
          out_load_o                = 1'b1;
          out_res_o.index           = sls_pkg::CH_W'(idx_q);
          out_res_o.angle           = angle_q;
          out_res_o.moved           = 1'b0;
          out_res_o.arrived         = ~|mis_d;
          out_res_o.last            = 1'b1;
          state_d                   = sls_pkg::ST_IDLE;
        end
      end

      sls_pkg::ST_STEP: begin
        // write back channel idx_q while the next channel is read
        if (out_free_i) begin
          mem_req_o.wr_en           = 1'b1;
          mem_req_o.wr_addr         = idx_q;
          mem_req_o.wr_data.cur     = step_cur;
          mem_req_o.wr_data.tgt     = rd_data_i.tgt;
          mem_req_o.wr_data.settled = arrived_q ? step_cur : rd_data_i.settled;
          mis_d[idx_q]              = step_cur != rd_data_i.tgt;
          far_d[idx_q]              = sls_pkg::far_apart(step_cur, rd_data_i.tgt);
          out_load_o                = 1'b1;
          out_res_o.index           = sls_pkg::CH_W'(idx_q);
          out_res_o.angle           = step_cur;
          out_res_o.moved           = step_moved;
          out_res_o.arrived         = arrived_q;
          out_res_o.last            = (idx_q == sls_pkg::LAST_IDX);
          if (idx_q == sls_pkg::LAST_IDX) begin
            if (arrived_q) begin
              pending_d = 1'b0;
            end
            state_d = sls_pkg::ST_IDLE;
          end else begin
            idx_d             = sls_pkg::IDX_W'(idx_q + 1'b1);
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = sls_pkg::IDX_W'(idx_q + 1'b1);
          end
        end
      end

      default: state_d = sls_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= sls_pkg::ST_IDLE;
      step_interval_q <= sls_pkg::STEP_INTERVAL_RST;
      tick_cnt_q      <= '0;
      pending_q       <= 1'b0;
      mis_q           <= '0;
      far_q           <= '0;
      arrived_q       <= 1'b0;
      idx_q           <= '0;
    end else begin
      state_q   <= state_d;
      tick_cnt_q <= tick_cnt_d;
      pending_q <= pending_d;
      mis_q     <= mis_d;
      far_q     <= far_d;
      arrived_q <= arrived_d;
      idx_q     <= idx_d;
      if (cfg_we_i) begin
        step_interval_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
  end

endmodule

@@ rtl/sls_out.sv @@
// output register: holds one result transaction until the sink takes it
// depends on sls_pkg
module sls_out (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  sls_pkg::result_t         res_i,
  output logic                     free_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [sls_pkg::CH_W-1:0] servo_index_o,
  output sls_pkg::angle_t          servo_angle_o,
  output logic                     moved_o,
  output logic                     all_arrived_o,
  output logic                     last_o
);

  logic             valid_q;
  sls_pkg::result_t res_q;

  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign servo_index_o = res_q.index;
  assign servo_angle_o = res_q.angle;
  assign moved_o       = res_q.moved;
  assign all_arrived_o = res_q.arrived;
  assign last_o        = res_q.last;

endmodule

@@ rtl/multi_servo_angle_slew_limiter_core.sv @@
// top level of the multi-channel servo slew limiter
// depends on sls_pkg, sls_store, sls_seq and sls_out
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_stall_o  operation_i channel_i angle_i
//   out      source     out_valid_o/out_stall_i servo_index_o servo_angle_o moved_o
//                                               all_arrived_o last_o
//   cfg      sink       cfg_we_i               cfg_wdata_i (step_interval)
//
// a stepping tick walks all NUM_SERVOS channels, one channel per cycle while the
//   output is free, via the angle store (write back one channel, read the next)
// set target first reads the channel's store entry; preset waits for a free output
// stalls on the output hold the channel walk; the input is stalled while busy
// reset leaves the store contents alone, per-entry valid bits give angle 90
module multi_servo_angle_slew_limiter_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sls_pkg::TICK_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sls_pkg::OP_W-1:0]     operation_i,
  input  logic [sls_pkg::CH_W-1:0]     channel_i,
  input  logic [sls_pkg::ANGLE_W-1:0]  angle_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sls_pkg::CH_W-1:0]     servo_index_o,
  output logic [sls_pkg::ANGLE_W-1:0]  servo_angle_o,
  output logic                         moved_o,
  output logic                         all_arrived_o,
  output logic                         last_o
);

  sls_pkg::mem_req_t mem_req;
  sls_pkg::entry_t   rd_data;
  logic              out_free;
  logic              out_load;
  sls_pkg::result_t  out_res;

  sls_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  sls_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .channel_i   (channel_i),
    .angle_i     (angle_i),
    .mem_req_o   (mem_req),
    .rd_data_i   (rd_data),
    .out_free_i  (out_free),
    .out_load_o  (out_load),
    .out_res_o   (out_res)
  );

  sls_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (out_load),
    .res_i         (out_res),
    .free_o        (out_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .servo_index_o (servo_index_o),
    .servo_angle_o (servo_angle_o),
    .moved_o       (moved_o),
    .all_arrived_o (all_arrived_o),
    .last_o        (last_o)
  );

endmodule

@@ rtl/sls_checker.sv @@
// port-level checker for the servo slew limiter, bound to the top level
// depends on sls_pkg and assert_macros.svh
`include "assert_macros.svh"

module sls_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [sls_pkg::CH_W-1:0]     servo_index_o,
  input logic [sls_pkg::ANGLE_W-1:0]  servo_angle_o,
  input logic                         moved_o,
  input logic                         all_arrived_o,
  input logic                         last_o
);

  logic [sls_pkg::CH_W+sls_pkg::ANGLE_W+2:0] out_word;

  assign out_word = {servo_index_o, servo_angle_o, moved_o, all_arrived_o, last_o};

  // a stalled result keeps every field
  `SLS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word), "stalled result changed")

  // reported angles never pass the saturation limit
  `SLS_ASSERT(a_angle_range, out_valid_o |-> (servo_angle_o <= sls_pkg::MAX_ANGLE), "angle above limit")

  // after a non-final result is taken the next one follows at once
  `SLS_ASSERT_NEXT(a_walk_continues, out_valid_o && !out_stall_i && !last_o, out_valid_o, "step walk broke off")

  // a new transaction is never taken while a walk result is still outstanding
  `SLS_ASSERT(a_no_accept_mid_walk, (out_valid_o && !last_o) |-> in_stall_o, "input taken mid walk")

endmodule

bind multi_servo_angle_slew_limiter_core sls_checker u_sls_checker (.*);

@@ dv/tb_multi_servo_angle_slew_limiter_core.sv @@
`timescale 1ns / 100ps
// testbench for the multi-channel servo slew limiter core: directed table, then random phases
// predicts every channel report and checks them in order; depends on sls_pkg and the core rtl
module tb_multi_servo_angle_slew_limiter_core;
  import sls_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 12;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 24;
  localparam int MAX_SHOWN     = 10;
  localparam int LONG_HOLD     = 300;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e       kind;
    op_e             op;
    logic [CH_W-1:0] ch;
    angle_t          angle;
    tick_t           cfg_value;
    logic            typed;
    result_t         report;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  tick_t               cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic [OP_W-1:0]     operation;
  logic [CH_W-1:0]     channel;
  angle_t              angle_in;
  logic                out_valid;
  logic                out_stall;
  logic [CH_W-1:0]     servo_index;
  angle_t              servo_angle;
  logic                moved;
  logic                all_arrived;
  logic                last;

  // predicted servo state
  angle_t  cur_deg     [NUM_SERVOS];
  angle_t  tgt_deg     [NUM_SERVOS];
  angle_t  settled_deg [NUM_SERVOS];
  logic    motion_due;
  tick_t   ticks_since;
  tick_t   interval;
  result_t report_q [$];

  // stimulus control
  logic      typed_now;
  result_t   typed_report_now;
  int        idle_pct;
  int        stall_pct;
  int        hold_left;
  int        cycles;
  int        mismatches;
  int        accepted;
  int        reports_checked;
  int        steps_seen;
  int        settings_written;
  stim_row_t directed_rows [$];

  multi_servo_angle_slew_limiter_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (operation),
    .channel_i     (channel),
    .angle_i       (angle_in),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .servo_index_o (servo_index),
    .servo_angle_o (servo_angle),
    .moved_o       (moved),
    .all_arrived_o (all_arrived),
    .last_o        (last)
  );

  always begin
    clk_i = 1'b0;
    #(CLK_HALF);
    clk_i = 1'b1;
    #(CLK_HALF);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports still expected", cycles, report_q.size());
      $display("multi_servo_angle_slew_limiter_core regression: fail");
      $finish;
    end
  end

  function automatic logic all_on_target();
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < NUM_SERVOS; i++) begin
      if (cur_deg[i] != tgt_deg[i]) ok = 1'b0;
    end
    return ok;
  endfunction

  // advance the servo state by one command and queue the reports it causes
  function automatic void predict_reports(input op_e op, input logic [CH_W-1:0] ch,
                                          input angle_t raw, input logic typed,
                                          input result_t typed_report);
    angle_t  a;
    logic    moved_now [NUM_SERVOS];
    logic    done;
    result_t r;
    a = (raw > MAX_ANGLE) ? MAX_ANGLE : raw;
    case (op)
      OP_TICK: begin
        if (ticks_since != TICK_MAX) ticks_since = ticks_since + 1'b1;
        if (motion_due && ticks_since >= interval) begin
          ticks_since = '0;
          steps_seen++;
          for (int i = 0; i < NUM_SERVOS; i++) begin
            moved_now[i] = (cur_deg[i] != tgt_deg[i]);
            if (cur_deg[i] < tgt_deg[i]) cur_deg[i] = cur_deg[i] + 8'd1;
            else if (cur_deg[i] > tgt_deg[i]) cur_deg[i] = cur_deg[i] - 8'd1;
          end
          done = all_on_target();
          if (done) begin
            motion_due = 1'b0;
            for (int i = 0; i < NUM_SERVOS; i++) settled_deg[i] = cur_deg[i];
          end
          for (int i = 0; i < NUM_SERVOS; i++) begin
            r.index   = i[CH_W-1:0];
            r.angle   = cur_deg[i];
            r.moved   = moved_now[i];
            r.arrived = done;
            r.last    = (i == NUM_SERVOS - 1);
            report_q.push_back(r);
          end
        end
      end
      OP_SET_TARGET: begin
        if (ch < NUM_SERVOS) begin
          if (settled_deg[ch] != a) begin
            tgt_deg[ch] = a;
            motion_due  = 1'b1;
          end else begin
            tgt_deg[ch] = settled_deg[ch];
          end
        end
      end
      OP_PRESET: begin
        if (ch < NUM_SERVOS) begin
          cur_deg[ch]     = a;
          tgt_deg[ch]     = a;
          settled_deg[ch] = a;
          r.index   = ch;
          r.angle   = a;
          r.moved   = 1'b0;
          r.arrived = all_on_target();
          r.last    = 1'b1;
          report_q.push_back(typed ? typed_report : r);
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall) begin
      predict_reports(op_e'(operation), channel, angle_in, typed_now, typed_report_now);
      accepted++;
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      got.index   = servo_index;
      got.angle   = servo_angle;
      got.moved   = moved;
      got.arrived = all_arrived;
      got.last    = last;
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("cycle %0d: unexpected report ch %0d angle %0d", cycles, got.index, got.angle);
      end else begin
        want = report_q.pop_front();
        reports_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("cycle %0d: expected ch %0d angle %0d moved %0b arrived %0b last %0b",
                     cycles, want.index, want.angle, want.moved, want.arrived, want.last);
            $display("  got ch %0d angle %0d moved %0b arrived %0b last %0b",
                     got.index, got.angle, got.moved, got.arrived, got.last);
          end
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_item(input op_e op, input logic [CH_W-1:0] ch, input angle_t a,
                           input logic typed, input result_t rep);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_valid = 1'b0;
    end
    @(negedge clk_i);
    in_valid         = 1'b1;
    operation        = op;
    channel          = ch;
    angle_in         = a;
    typed_now        = typed;
    typed_report_now = rep;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (report_q.size() != 0) @(negedge clk_i);
    // a set target or quiet tick may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_interval(input tick_t value);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    interval  = value;
    settings_written++;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic send_random();
    int               r;
    logic [CH_W-1:0]  ch;
    angle_t           a;
    op_e              op;
    r  = $urandom_range(99);
    ch = CH_W'($urandom_range(NUM_SERVOS - 1));
    // mostly small moves around the present angle so motions complete
    if ($urandom_range(3) == 0) a = angle_t'($urandom_range(255));
    else a = angle_t'(cur_deg[ch] + $urandom_range(6) - 3);
    if (r < 55) op = OP_TICK;
    else if (r < 80) op = OP_SET_TARGET;
    else if (r < 96) op = OP_PRESET;
    else op = OP_UNUSED;
    send_item(op, ch, a, 1'b0, '0);
  endtask

  task automatic run_phase(input tick_t value, input int idle, input int stall,
                           input int count, input int pause_at);
    write_interval(value);
    idle_pct  = idle;
    stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      if (n == pause_at) wait_idle();
      send_random();
    end
  endtask

  function automatic void add_item(input op_e op, input logic [CH_W-1:0] ch, input angle_t a);
    stim_row_t row;
    row.kind      = ROW_ITEM;
    row.op        = op;
    row.ch        = ch;
    row.angle     = a;
    row.cfg_value = '0;
    row.typed     = 1'b0;
    row.report    = '0;
    directed_rows.push_back(row);
  endfunction

  // preset row whose report is obvious: moved low, last high
  function automatic void add_preset(input logic [CH_W-1:0] ch, input angle_t a,
                                     input angle_t exp_angle, input logic exp_arrived);
    stim_row_t row;
    row.kind           = ROW_ITEM;
    row.op             = OP_PRESET;
    row.ch             = ch;
    row.angle          = a;
    row.cfg_value      = '0;
    row.typed          = 1'b1;
    row.report.index   = ch;
    row.report.angle   = exp_angle;
    row.report.moved   = 1'b0;
    row.report.arrived = exp_arrived;
    row.report.last    = 1'b1;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input tick_t value);
    stim_row_t row;
    row.kind      = ROW_CFG;
    row.op        = OP_TICK;
    row.ch        = '0;
    row.angle     = '0;
    row.cfg_value = value;
    row.typed     = 1'b0;
    row.report    = '0;
    directed_rows.push_back(row);
  endfunction

  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    operation        = OP_TICK;
    channel          = '0;
    angle_in         = '0;
    out_stall        = 1'b0;
    typed_now        = 1'b0;
    typed_report_now = '0;
    idle_pct         = 0;
    stall_pct        = 0;
    hold_left        = 0;
    cycles           = 0;
    mismatches       = 0;
    accepted         = 0;
    reports_checked  = 0;
    steps_seen       = 0;
    settings_written = 0;
    for (int i = 0; i < NUM_SERVOS; i++) begin
      cur_deg[i]     = RESET_ANGLE;
      tgt_deg[i]     = RESET_ANGLE;
      settled_deg[i] = RESET_ANGLE;
    end
    motion_due  = 1'b0;
    ticks_since = '0;
    interval    = STEP_INTERVAL_RST;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // saturation of requested angles, unused code, quiet ticks
    add_preset(3'd0, 8'd255, 8'd180, 1'b1);
    add_preset(3'd7, 8'd0, 8'd0, 1'b1);
    add_preset(3'd3, 8'd180, 8'd180, 1'b1);
    add_preset(3'd5, 8'd181, 8'd180, 1'b1);
    add_item(OP_UNUSED, 3'd2, 8'd77);
    add_item(OP_TICK, 3'd0, 8'd0);
    add_item(OP_SET_TARGET, 3'd1, 8'd90);
    add_item(OP_TICK, 3'd0, 8'd0);
    // interval of one: one real move, preset while pending, empty step
    add_cfg(10'd1);
    add_item(OP_SET_TARGET, 3'd1, 8'd92);
    add_item(OP_TICK, 3'd0, 8'd0);
    add_preset(3'd1, 8'd100, 8'd100, 1'b1);
    add_item(OP_TICK, 3'd0, 8'd0);
    add_item(OP_TICK, 3'd0, 8'd0);
    // target put back to the settled angle leaves pending set
    add_item(OP_SET_TARGET, 3'd2, 8'd255);
    add_item(OP_SET_TARGET, 3'd2, 8'd90);
    add_item(OP_TICK, 3'd0, 8'd0);
    // zero interval steps on every tick
    add_cfg(10'd0);
    add_item(OP_SET_TARGET, 3'd6, 8'd0);
    add_item(OP_TICK, 3'd0, 8'd0);
    add_item(OP_TICK, 3'd0, 8'd0);
    add_item(OP_SET_TARGET, 3'd6, 8'd200);
    add_item(OP_TICK, 3'd0, 8'd0);
    add_cfg(10'd1023);
    add_item(OP_TICK, 3'd0, 8'd0);
    add_preset(3'd6, 8'd89, 8'd89, 1'b1);
    add_item(OP_UNUSED, 3'd7, 8'd255);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_CFG) begin
        write_interval(directed_rows[k].cfg_value);
      end else begin
        send_item(directed_rows[k].op, directed_rows[k].ch, directed_rows[k].angle,
                  directed_rows[k].typed, directed_rows[k].report);
      end
    end

    // long receiver hold-off with the sender pushing: the core backs up and stalls its input
    wait_idle();
    hold_left = LONG_HOLD;
    run_phase(10'd2, 0, 0, 45, -1);
    run_phase(10'd0, 82, 0, 45, -1);
    run_phase(10'd1, 0, 82, 50, 25);
    run_phase(10'd3, 24, 24, 47, -1);

    wait_idle();
    if (report_q.size() != 0) begin
      mismatches += report_q.size();
      $display("%0d expected reports never arrived", report_q.size());
    end
    $display("%0d transactions in, %0d channel reports checked, %0d of them from %0d steps",
             accepted, reports_checked, steps_seen * NUM_SERVOS, steps_seen);
    $display("%0d interval settings incl. 0, 1 and 1023; long output hold and a drained pause",
             settings_written);
    if (mismatches == 0) begin
      $display("multi_servo_angle_slew_limiter_core regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("multi_servo_angle_slew_limiter_core regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/sls_pkg.sv
rtl/sls_store.sv
rtl/sls_seq.sv
rtl/sls_out.sv
rtl/multi_servo_angle_slew_limiter_core.sv
rtl/sls_checker.sv
dv/tb_multi_servo_angle_slew_limiter_core.sv
